@@ hw/rtl/lkvc_pkg.sv @@
// lkvc_pkg: shared types and constants for the LRU key-value cache.
// Used by lkvc_ctrl, lkvc_datapath and lru_key_value_cache_core; no dependencies.
`timescale 1ns / 1ps

package lkvc_pkg;

  // Operation codes on the kind field
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // Capacity register
  localparam int         CAP_W     = 5;
  localparam logic [4:0] CAP_RESET = 5'd16;

  // Value returned on a lookup miss
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch the accepted request
    logic look;      // compare keys, register hit and victim vectors
    logic commit;    // apply the state update
    logic load_out;  // load the response register
  } lkvc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_get;    // latched request is a lookup
  } lkvc_status_t;

endpackage

@@ hw/rtl/lkvc_ctrl.sv @@
// lkvc_ctrl: request sequencer and response handshake for the LRU cache.
// Depends on lkvc_pkg for the command and status structs.
`timescale 1ns / 1ps

module lkvc_ctrl import lkvc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  lkvc_status_t status,
  output lkvc_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOK   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       in_fire;

  // no request is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;
  assign in_fire  = in_valid && in_ready;
  // response slot can take a new result this cycle
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.look     = 1'b0;
    cmd.commit   = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // a lookup waits here until its result has somewhere to go
        if (!status.is_get || out_free) begin
          cmd.commit   = 1'b1;
          cmd.load_out = status.is_get;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // response valid: set on load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/lkvc_datapath.sv @@
// lkvc_datapath: entry storage, key compare, recency ranks and response register.
// Depends on lkvc_pkg; driven by lkvc_ctrl commands.
`timescale 1ns / 1ps

module lkvc_datapath import lkvc_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  lkvc_cmd_t           cmd,
  output lkvc_status_t        status,
  input  logic                cfg_write_en,
  input  logic [CAP_W-1:0]    cfg_write_data,
  input  logic                kind,
  input  logic signed [31:0]  lookup_key,
  input  logic signed [31:0]  store_value,
  output logic                found,
  output logic signed [31:0]  read_value
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // configuration
  logic [CAP_W-1:0] capacity;

  // latched request
  logic                kind_q;
  logic [KEY_BITS-1:0] key_q;
  logic [31:0]         val_q;
  logic [63:0]         key_wide;

  // entry state
  logic [KEY_BITS-1:0] keys   [ENTRIES];
  logic [31:0]         values [ENTRIES];
  logic [RANK_W-1:0]   rank   [ENTRIES];
  logic [ENTRIES-1:0]  valid;
  logic [OCC_W-1:0]    occ;

  // lookup results
  logic [ENTRIES-1:0]  hit_vec;
  logic [ENTRIES-1:0]  victim_vec;
  logic [RANK_W-1:0]   hit_rank;
  logic [31:0]         hit_val;
  logic                need_evict;
  logic                hit_any;

  logic [RANK_W-1:0]   hit_rank_c;
  logic [31:0]         hit_val_c;
  logic [OCC_W-1:0]    occ_m1;
  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    eff_cap;

  // insert slot selection
  logic [ENTRIES-1:0]  evict_vec;
  logic [ENTRIES-1:0]  avail;
  logic [ENTRIES-1:0]  ins_vec;
  logic [ENTRIES-1:0]  valid_after;

  assign key_wide      = {{32{lookup_key[31]}}, lookup_key};
  assign hit_any       = |hit_vec;
  assign status.is_get = (kind_q == KIND_GET);
  assign occ_m1        = occ - OCC_W'(1);

  // capacity: zero acts as one, saturate at the entry count
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write_en) begin
      capacity <= cfg_write_data;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      key_q  <= key_wide[KEY_BITS-1:0];
      val_q  <= store_value;
    end
  end

  // one-hot select of the hit entry's rank and value
  always_comb begin
    hit_rank_c = '0;
    hit_val_c  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i] && (keys[i] == key_q)) begin
        hit_rank_c = hit_rank_c | rank[i];
        hit_val_c  = hit_val_c | values[i];
      end
    end
  end

  // key compare stage; victim is the valid entry holding the oldest rank
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hit_vec[i]    <= valid[i] && (keys[i] == key_q);
        victim_vec[i] <= valid[i] && (OCC_W'(rank[i]) == occ_m1);
      end
      hit_rank   <= hit_rank_c;
      hit_val    <= hit_val_c;
      need_evict <= (CMP_W'(occ) >= eff_cap);
    end
  end

  // insert goes to the lowest free slot once the victim is dropped
  always_comb begin
    evict_vec   = need_evict ? victim_vec : '0;
    valid_after = valid & ~evict_vec;
    avail       = ~valid_after;
    ins_vec     = avail & (~avail + ENTRIES'(1));
  end

  // entry payload and rank update
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_any) begin
          if (hit_vec[i]) begin
            rank[i] <= '0;
            if (kind_q == KIND_PUT) begin
              values[i] <= val_q;
            end
          end else if (valid[i] && (rank[i] < hit_rank)) begin
            rank[i] <= rank[i] + RANK_W'(1);
          end
        end else if (kind_q == KIND_PUT) begin
          if (ins_vec[i]) begin
            keys[i]   <= key_q;
            values[i] <= val_q;
            rank[i]   <= '0;
          end else if (valid_after[i]) begin
            rank[i] <= rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  // valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
    end else if (cmd.commit && !hit_any && (kind_q == KIND_PUT) && (|ins_vec)) begin
      valid <= valid_after | ins_vec;
      if (!need_evict) begin
        occ <= occ + OCC_W'(1);
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found      <= hit_any;
      read_value <= hit_any ? hit_val : MISS_VALUE;
    end
  end

endmodule

@@ hw/rtl/lru_key_value_cache_core.sv @@
// lru_key_value_cache_core: top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   request  | in_valid / in_ready  | kind, lookup_key, store_value
//   response | out_valid/out_ready  | found, read_value (lookups only)
//   config   | cfg_write_en         | cfg_write_data (capacity_in_use)
//
// Each request goes through accept, a parallel key compare over all entries,
// then the commit of values, valid bits and recency ranks; a new request is
// accepted the cycle after the commit. A lookup result sits in an output
// register; a lookup holds in its commit cycle while that register is full and
// not being taken. rst is synchronous: the cache comes up empty with capacity 16.
`timescale 1ns / 1ps

module lru_key_value_cache_core import lkvc_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [CAP_W-1:0]   cfg_write_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [31:0] lookup_key,
  input  logic signed [31:0] store_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic signed [31:0] read_value
);

  lkvc_cmd_t    cmd;
  lkvc_status_t status;

  // sequencer
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // storage and compare datapath
  lkvc_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .kind           (kind),
    .lookup_key     (lookup_key),
    .store_value    (store_value),
    .found          (found),
    .read_value     (read_value)
  );

endmodule
